// ----- hdl/fmkf_pkg.sv -----
package fmkf_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int MAX_LENGTH_DEF = 65536;

    localparam int SYM_W    = 8;
    localparam int WLEN_W   = 6;
    localparam int BASE_W   = 8;
    localparam int POW_W    = 32;
    localparam int HASH_W   = 64;
    localparam int OFFSET_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_BASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_POWER     = 2'd2;

    localparam logic [WLEN_W-1:0] WLEN_RESET  = 6'd5;
    localparam logic [BASE_W-1:0] BASE_RESET  = 8'd7;
    localparam logic [POW_W-1:0]  POWER_RESET = 32'd2401;

    // One request to the shared multiply-add unit: res = a * b + c.
    typedef struct packed {
        logic              en;
        logic [HASH_W-1:0] a;
        logic [SYM_W-1:0]  b;
        logic [SYM_W-1:0]  c;
    } mac_req_t;

endpackage

// ----- hdl/fmkf_pair_if.sv -----
interface fmkf_pair_if;
    import fmkf_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] first_symbol;
    logic [SYM_W-1:0] second_symbol;
    logic             last_pair;

    modport source (output valid, output first_symbol, output second_symbol,
                    output last_pair, input ready);
    modport sink (input valid, input first_symbol, input second_symbol,
                  input last_pair, output ready);
endinterface

// ----- hdl/fmkf_res_if.sv -----
interface fmkf_res_if;
    import fmkf_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] border_offset;
    logic                matched;
    logic                too_short;

    modport source (output valid, output border_offset, output matched,
                    output too_short, input ready);
    modport sink (input valid, input border_offset, input matched,
                  input too_short, output ready);
endinterface

// ----- hdl/fmkf_cfg_if.sv -----
interface fmkf_cfg_if;
    import fmkf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/first_matching_kmer_finder.sv -----
// First matching k-mer finder: two aligned byte streams arrive as pairs on
// the symbols channel (valid/ready); last_pair ends a sequence. For each
// stream a polynomial rolling hash over the last k symbols is kept, and on
// the last pair one item leaves on the result channel: the start of the
// first window with equal hashes (matched=1), else length minus k, or
// too_short=1 when fewer than k pairs arrived. Other pairs give no item.
// The cfg channel writes the window length, the polynomial base and the top
// power; it is always ready. The user must write it only while the block is
// idle; the block does not enforce this. One shared multiply-add unit under
// a sequencer handles each pair: two Horner steps (M0, M1, W1, UPD) while
// the first window fills; once it rolls, first two 32-bit products and two
// subtracts (P0, S0, S1), then the Horner steps. A last pair then passes
// FIN; pairs past the length limit skip the steps. symbols.ready is high
// only while the sequencer is idle. A result waits in an output register
// until taken; the next pair is accepted meanwhile, and only the next last
// pair stalls behind it. Reset restores the register defaults and clears
// hashes and counters; no clearing pass is needed for the window buffer.
module first_matching_kmer_finder #(
    parameter int MAX_WINDOW = fmkf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_LENGTH = fmkf_pkg::MAX_LENGTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fmkf_cfg_if.sink   cfg,
    fmkf_pair_if.sink  symbols,
    fmkf_res_if.source result
);
    import fmkf_pkg::*;

    localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW  = $clog2(MAX_WINDOW + 1);
    localparam int KCW = (KW > WLEN_W) ? KW : WLEN_W;
    localparam int DW  = KW + 1;
    localparam int CW  = $clog2(MAX_LENGTH + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_P0   = 4'd1;
    localparam logic [3:0] ST_S0   = 4'd2;
    localparam logic [3:0] ST_S1   = 4'd3;
    localparam logic [3:0] ST_M0   = 4'd4;
    localparam logic [3:0] ST_M1   = 4'd5;
    localparam logic [3:0] ST_W1   = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [WLEN_W-1:0] wlen_reg;
    logic [BASE_W-1:0] base_reg;
    logic [POW_W-1:0]  power_reg;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [SYM_W-1:0]    a_reg;
    logic [SYM_W-1:0]    b_reg;
    logic                last_reg;
    logic [KW-1:0]       k_reg;
    logic [HASH_W-1:0]   ha_reg;
    logic [HASH_W-1:0]   hb_reg;
    logic [CW-1:0]       count_reg;
    logic [PW-1:0]       ptr_reg;
    logic                found_reg;
    logic [OFFSET_W-1:0] found_off_reg;

    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_matched_reg;
    logic                out_short_reg;

    logic                accept;
    logic [KCW-1:0]      wlen_ext;
    logic [KW-1:0]       k_eff;
    logic [DW-1:0]       old_diff;
    logic [DW-1:0]       old_wrap;
    logic [PW-1:0]       old_addr;
    logic                in_range;
    logic [CW-1:0]       count_inc;
    logic [CW-1:0]       k_ext;
    logic                out_free;
    logic                match_now;

    mac_req_t            mac_req;
    logic [HASH_W-1:0]   mac_res;
    logic [2*SYM_W-1:0]  rd_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg  <= WLEN_RESET;
            base_reg  <= BASE_RESET;
            power_reg <= POWER_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WINDOW_LENGTH: wlen_reg  <= cfg.data[WLEN_W-1:0];
                CFG_HASH_BASE:     base_reg  <= cfg.data[BASE_W-1:0];
                CFG_TOP_POWER:     power_reg <= cfg.data[POW_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective window length, clamped into 1..MAX_WINDOW.
    always_comb
    begin
        wlen_ext = KCW'(wlen_reg);
        if (wlen_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (wlen_ext > KCW'(MAX_WINDOW))
        begin
            k_eff = KW'(MAX_WINDOW);
        end
        else
        begin
            k_eff = KW'(wlen_ext);
        end
    end

    // Slot of the symbol leaving the window: (ptr - k) mod MAX_WINDOW.
    assign old_diff = DW'(ptr_reg) - DW'(k_eff);
    assign old_wrap = old_diff[DW-1] ? (old_diff + DW'(MAX_WINDOW)) : old_diff;
    assign old_addr = PW'(old_wrap);

    assign accept    = symbols.valid && symbols.ready;
    assign in_range  = count_reg < CW'(MAX_LENGTH);
    assign count_inc = count_reg + CW'(1);
    assign k_ext     = CW'(k_reg);
    assign out_free  = !out_valid_reg || result.ready;
    assign match_now = (count_inc >= k_ext) && !found_reg && (ha_reg == hb_reg);

    assign symbols.ready = (state_reg == ST_IDLE);

    fmkf_ram #(
        .WIDTH (2 * SYM_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (state_reg == ST_UPD),
        .wr_addr (ptr_reg),
        .wr_data ({b_reg, a_reg}),
        .rd_en   (accept),
        .rd_addr (old_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        mac_req.en = 1'b0;
        mac_req.a  = '0;
        mac_req.b  = '0;
        mac_req.c  = '0;
        case (state_reg)
            ST_P0:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = HASH_W'(power_reg);
                mac_req.b  = rd_data[SYM_W-1:0];
            end
            ST_S0:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = HASH_W'(power_reg);
                mac_req.b  = rd_data[2*SYM_W-1:SYM_W];
            end
            ST_M0:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = ha_reg;
                mac_req.b  = base_reg;
                mac_req.c  = a_reg;
            end
            ST_M1:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = hb_reg;
                mac_req.b  = base_reg;
                mac_req.c  = b_reg;
            end
            default: ;
        endcase
    end

    fmkf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .res   (mac_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_range)
                    begin
                        state_next = symbols.last_pair ? ST_FIN : ST_IDLE;
                    end
                    else if (count_reg < CW'(k_eff))
                    begin
                        state_next = ST_M0;
                    end
                    else
                    begin
                        state_next = ST_P0;
                    end
                end
            end
            ST_P0:   state_next = ST_S0;
            ST_S0:   state_next = ST_S1;
            ST_S1:   state_next = ST_M0;
            ST_M0:   state_next = ST_M1;
            ST_M1:   state_next = ST_W1;
            ST_W1:   state_next = ST_UPD;
            ST_UPD:  state_next = last_reg ? ST_FIN : ST_IDLE;
            ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            k_reg         <= '0;
            ha_reg        <= '0;
            hb_reg        <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            found_off_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= symbols.last_pair;
                        k_reg    <= k_eff;
                    end
                end
                // Remove the leaving symbol's term before the Horner step.
                ST_S0: ha_reg <= ha_reg - HASH_W'(mac_res[POW_W-1:0]);
                ST_S1: hb_reg <= hb_reg - HASH_W'(mac_res[POW_W-1:0]);
                ST_M1: ha_reg <= mac_res;
                ST_W1: hb_reg <= mac_res;
                ST_UPD:
                begin
                    count_reg <= count_inc;
                    ptr_reg   <= (ptr_reg == PW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + PW'(1);
                    if (match_now)
                    begin
                        found_reg     <= 1'b1;
                        found_off_reg <= OFFSET_W'(count_inc - k_ext);
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        ha_reg        <= '0;
                        hb_reg        <= '0;
                        count_reg     <= '0;
                        ptr_reg       <= '0;
                        found_reg     <= 1'b0;
                        found_off_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= symbols.first_symbol;
            b_reg <= symbols.second_symbol;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            if (count_reg < k_ext)
            begin
                out_offset_reg  <= '0;
                out_matched_reg <= 1'b0;
                out_short_reg   <= 1'b1;
            end
            else if (found_reg)
            begin
                out_offset_reg  <= found_off_reg;
                out_matched_reg <= 1'b1;
                out_short_reg   <= 1'b0;
            end
            else
            begin
                out_offset_reg  <= OFFSET_W'(count_reg - k_ext);
                out_matched_reg <= 1'b0;
                out_short_reg   <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.border_offset = out_offset_reg;
    assign result.matched       = out_matched_reg;
    assign result.too_short     = out_short_reg;
endmodule

// ----- hdl/fmkf_ram.sv -----
module fmkf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- hdl/fmkf_mac.sv -----
module fmkf_mac (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fmkf_pkg::mac_req_t        req,
    output logic [fmkf_pkg::HASH_W-1:0] res
);
    import fmkf_pkg::*;

    logic [HASH_W-1:0] res_reg;
    logic [HASH_W-1:0] res_next;

    // Products wrap at 64 bits, matching the hash arithmetic.
    assign res_next = req.a * HASH_W'(req.b) + HASH_W'(req.c);
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (req.en)
        begin
            res_reg <= res_next;
        end
    end
endmodule
